// ----- hw/rtl/mns_pkg.sv -----
// Shared types, character codes and tables for the MML note sequencer.
package mns_pkg;

	typedef enum logic [3:0] {
		M_IDLE      = 4'd0,
		M_NOTE_ACC  = 4'd1,
		M_NOTE_BASE = 4'd2,
		M_NOTE_DIG  = 4'd3,
		M_NOTE_DOT  = 4'd4,
		M_NUM_O     = 4'd5,
		M_NUM_Q     = 4'd6,
		M_NUM_L     = 4'd7,
		M_NUM_T     = 4'd8,
		M_L_DOT     = 4'd9,
		M_EXT       = 4'd10
	} parse_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_DIV_LEN,
		S_SECOND,
		S_DIV_TOT,
		S_NOTE,
		S_THIRD,
		S_ERR
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FIRST,
		OP_LEN_WB,
		OP_SECOND,
		OP_THIRD,
		OP_LD_NOTE,
		OP_LD_ERR
	} dp_op_t;

	typedef struct packed {
		logic   ld_byte;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic f_err;
		logic f_done;
		logic f_div;
		logic s_done;
		logic s_div;
		logic t_err;
		logic tie;
		logic div_busy;
		logic slot_free;
	} dp_status_t;

	localparam logic [1:0] EV_NOTE  = 2'd0;
	localparam logic [1:0] EV_REST  = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_Q     = 8'h51;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_DOLR  = 8'h24;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic [4:0] TOP_SHIFT = 5'd17;

	function automatic logic [30:0] tone_tab(input logic [3:0] i);
		logic [30:0] v;
		unique case (i)
			4'd0:    v = 31'd1071618315;
			4'd1:    v = 31'd1135340056;
			4'd2:    v = 31'd1202850889;
			4'd3:    v = 31'd1274376125;
			4'd4:    v = 31'd1350154473;
			4'd5:    v = 31'd1430438836;
			4'd6:    v = 31'd1515497155;
			4'd7:    v = 31'd1605613306;
			4'd8:    v = 31'd1701088041;
			4'd9:    v = 31'd1802240000;
			4'd10:   v = 31'd1909406767;
			4'd11:   v = 31'd2022946002;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] letter_ofs(input logic [2:0] i);
		logic [3:0] v;
		unique case (i)
			3'd0:    v = 4'd9;
			3'd1:    v = 4'd11;
			3'd2:    v = 4'd0;
			3'd3:    v = 4'd2;
			3'd4:    v = 4'd4;
			3'd5:    v = 4'd5;
			3'd6:    v = 4'd7;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	// idx / 12 by reciprocal, exact for 8-bit idx
	function automatic logic [4:0] div12(input logic [7:0] idx);
		logic [15:0] p;
		p = 16'(idx) * 16'd171;
		return p[15:11];
	endfunction

endpackage

// ----- hw/rtl/mml_note_sequencer_unit.sv -----
// Top level of the MML note sequencer: controller plus datapath.
// Input channel: in_valid/in_ready carry one text byte per word.
// Output channel: out_valid/out_ready carry one event word (note, rest or
// syntax error) with tone, tick counts, tie flag and last_of_run.
// A byte gives zero, one or two words; last_of_run marks the final one.
// A byte that closes a note runs the shared 24-step restoring divider
// (length*125/tempo) before its note word is loaded, and one that closes
// a numeric length runs it as well for WHOLE/n.
// One byte is worked at a time; in_ready is high only between bytes.
// The result register holds one word: while the receiver stalls, the
// unit waits before loading the next word but may already take a byte.
// Reset sets octave 4, length of a quarter note, tempo 120, quantize 7,
// clears the parse state and drops any pending output word.
module mml_note_sequencer_unit #(
	parameter int TICK_WIDTH       = 16,
	parameter int WHOLE_NOTE_UNITS = 192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [30:0] tone_value,
	output logic        tone_changed,
	output logic [15:0] sound_ticks,
	output logic [15:0] total_ticks,
	output logic        tied,
	output logic        last_of_run
);

	mns_pkg::dp_cmd_t    cmd;
	mns_pkg::dp_status_t st;

	mns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	mns_dp #(
		.TICK_WIDTH       (TICK_WIDTH),
		.WHOLE_NOTE_UNITS (WHOLE_NOTE_UNITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.text_byte    (text_byte),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.tone_value   (tone_value),
		.tone_changed (tone_changed),
		.sound_ticks  (sound_ticks),
		.total_ticks  (total_ticks),
		.tied         (tied),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- hw/rtl/mns_ctrl.sv -----
// Sequencing state machine for the MML note sequencer.
module mns_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mns_pkg::dp_status_t st,
	output mns_pkg::dp_cmd_t    cmd
);

	mns_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mns_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mns_pkg::S_IDLE: begin
				if (in_valid) state_d = mns_pkg::S_FIRST;
			end
			mns_pkg::S_FIRST: begin
				priority if (st.f_err) state_d = mns_pkg::S_ERR;
				else if (st.f_done) state_d = mns_pkg::S_IDLE;
				else if (st.f_div) state_d = mns_pkg::S_DIV_LEN;
				else state_d = mns_pkg::S_SECOND;
			end
			mns_pkg::S_DIV_LEN: begin
				if (!st.div_busy) state_d = mns_pkg::S_SECOND;
			end
			mns_pkg::S_SECOND: begin
				priority if (st.s_done) state_d = mns_pkg::S_IDLE;
				else if (st.s_div) state_d = mns_pkg::S_DIV_TOT;
				else state_d = mns_pkg::S_THIRD;
			end
			mns_pkg::S_DIV_TOT: begin
				if (!st.div_busy) state_d = mns_pkg::S_NOTE;
			end
			mns_pkg::S_NOTE: begin
				if (st.slot_free) state_d = st.tie ? mns_pkg::S_IDLE : mns_pkg::S_THIRD;
			end
			mns_pkg::S_THIRD: begin
				state_d = st.t_err ? mns_pkg::S_ERR : mns_pkg::S_IDLE;
			end
			mns_pkg::S_ERR: begin
				if (st.slot_free) state_d = mns_pkg::S_IDLE;
			end
			default: state_d = mns_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.ld_byte = 1'b0;
		cmd.op      = mns_pkg::OP_NONE;
		unique case (state_q)
			mns_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.ld_byte = in_valid;
			end
			mns_pkg::S_FIRST:   cmd.op = mns_pkg::OP_FIRST;
			mns_pkg::S_DIV_LEN: begin
				if (!st.div_busy) cmd.op = mns_pkg::OP_LEN_WB;
			end
			mns_pkg::S_SECOND:  cmd.op = mns_pkg::OP_SECOND;
			mns_pkg::S_DIV_TOT: cmd.op = mns_pkg::OP_NONE;
			mns_pkg::S_NOTE: begin
				if (st.slot_free) cmd.op = mns_pkg::OP_LD_NOTE;
			end
			mns_pkg::S_THIRD:   cmd.op = mns_pkg::OP_THIRD;
			mns_pkg::S_ERR: begin
				if (st.slot_free) cmd.op = mns_pkg::OP_LD_ERR;
			end
			default: cmd.op = mns_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- hw/rtl/mns_dp.sv -----
// Datapath of the MML note sequencer: parse state, shared divider, result register.
module mns_dp #(
	parameter int TICK_WIDTH       = 16,
	parameter int WHOLE_NOTE_UNITS = 192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mns_pkg::dp_cmd_t    cmd,
	input  logic [7:0]          text_byte,
	output mns_pkg::dp_status_t st,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          event_kind,
	output logic [30:0]         tone_value,
	output logic                tone_changed,
	output logic [15:0]         sound_ticks,
	output logic [15:0]         total_ticks,
	output logic                tied,
	output logic                last_of_run
);

	localparam logic [15:0] TICK_LIM = (TICK_WIDTH >= 16) ? 16'hFFFF
		: 16'((64'd1 << TICK_WIDTH) - 64'd1);
	localparam logic [23:0] WHOLE = 24'(WHOLE_NOTE_UNITS);
	localparam logic [8:0]  DEF_LEN = 9'(WHOLE_NOTE_UNITS / 4);
	localparam int          DIV_STEPS = 24;

	typedef enum logic [3:0] {
		F_ACCUM, F_ACCID, F_FIRSTDIG, F_TO_DOT, F_NDIG_ERR, F_NDIG_DIV, F_OQ,
		F_T_ERR, F_T_SET, F_L_ERR, F_L_DIV, F_EXT, F_PASS
	} first_act_t;

	logic [7:0]  byte_q;
	logic [3:0]  octave_q;
	logic [8:0]  default_length_q;
	logic [7:0]  tempo_q;
	logic [3:0]  quantize_q;
	logic [7:0]  last_tone_q;
	mns_pkg::parse_mode_t mode_q, wm_q;
	logic [7:0]  acc_q;
	logic [7:0]  pti_q;
	logic        prest_q;
	logic [15:0] plen_q;
	logic        tie_q;
	logic        len_to_default_q;

	logic [23:0] dvd_q;
	logic [7:0]  rem_q;
	logic [7:0]  dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic [30:0] tone_q;
	logic        chg_q;
	logic [15:0] snd_q;
	logic [15:0] tot_q;
	logic        tied_q;
	logic        last_q;

	logic        is_dig, is_acc, is_letter, idle_err;
	logic [3:0]  dval;
	first_act_t  fa;
	logic [11:0] acc_next;
	logic [8:0]  rs;
	logic        rs_ge;
	logic [16:0] pl_ext;
	logic [9:0]  dl_ext;
	logic [7:0]  idx;
	logic [15:0] tot_sat;
	logic [19:0] snd_prod;
	logic [4:0]  idx_hi;
	logic [3:0]  idx_lo;
	logic [4:0]  shamt;
	logic        slot_free;
	logic        ld_word;
	logic        cut_short;

	assign is_dig    = (byte_q >= mns_pkg::CH_0) && (byte_q <= mns_pkg::CH_9);
	assign is_acc    = (byte_q == mns_pkg::CH_PLUS) || (byte_q == mns_pkg::CH_HASH)
		|| (byte_q == mns_pkg::CH_MINUS);
	assign is_letter = (byte_q >= mns_pkg::CH_A) && (byte_q <= mns_pkg::CH_G);
	assign dval      = 4'(byte_q - mns_pkg::CH_0);
	assign idle_err  = !(is_letter || byte_q == mns_pkg::CH_R || byte_q == mns_pkg::CH_LT
		|| byte_q == mns_pkg::CH_GT || byte_q == mns_pkg::CH_O || byte_q == mns_pkg::CH_Q
		|| byte_q == mns_pkg::CH_L || byte_q == mns_pkg::CH_T
		|| byte_q == mns_pkg::CH_DOLR || byte_q == mns_pkg::CH_NUL);
	assign acc_next  = 12'(acc_q) * 12'd10 + 12'(dval);
	assign slot_free = !ov_q || out_ready;
	assign ld_word   = (cmd.op == mns_pkg::OP_LD_NOTE) || (cmd.op == mns_pkg::OP_LD_ERR);
	assign cut_short = !prest_q && quantize_q < 4'd8 && !tie_q;

	always_comb begin
		priority if (is_dig && (mode_q == mns_pkg::M_NOTE_DIG || mode_q == mns_pkg::M_NUM_O
				|| mode_q == mns_pkg::M_NUM_Q || mode_q == mns_pkg::M_NUM_L
				|| mode_q == mns_pkg::M_NUM_T)) fa = F_ACCUM;
		else if (mode_q == mns_pkg::M_NOTE_ACC && is_acc) fa = F_ACCID;
		else if ((mode_q == mns_pkg::M_NOTE_ACC || mode_q == mns_pkg::M_NOTE_BASE) && is_dig)
			fa = F_FIRSTDIG;
		else if (mode_q == mns_pkg::M_NOTE_ACC || mode_q == mns_pkg::M_NOTE_BASE) fa = F_TO_DOT;
		else if (mode_q == mns_pkg::M_NOTE_DIG) fa = (acc_q == 8'd0) ? F_NDIG_ERR : F_NDIG_DIV;
		else if (mode_q == mns_pkg::M_NUM_O || mode_q == mns_pkg::M_NUM_Q) fa = F_OQ;
		else if (mode_q == mns_pkg::M_NUM_T) fa = (acc_q == 8'd0) ? F_T_ERR : F_T_SET;
		else if (mode_q == mns_pkg::M_NUM_L) fa = (acc_q == 8'd0) ? F_L_ERR : F_L_DIV;
		else if (mode_q == mns_pkg::M_EXT) fa = F_EXT;
		else fa = F_PASS;
	end

	always_comb begin
		st.f_err  = (fa == F_NDIG_ERR) || (fa == F_T_ERR) || (fa == F_L_ERR)
			|| (fa == F_EXT && byte_q == mns_pkg::CH_NUL);
		st.f_done = (fa == F_ACCUM) || (fa == F_ACCID) || (fa == F_FIRSTDIG) || (fa == F_EXT);
		st.f_div  = (fa == F_NDIG_DIV) || (fa == F_L_DIV);
		st.s_done = (wm_q == mns_pkg::M_NOTE_DOT || wm_q == mns_pkg::M_L_DOT)
			&& byte_q == mns_pkg::CH_DOT;
		st.s_div  = wm_q == mns_pkg::M_NOTE_DOT && byte_q != mns_pkg::CH_DOT;
		st.t_err  = idle_err;
		st.tie    = tie_q;
		st.div_busy  = busy_q;
		st.slot_free = slot_free;
	end

	assign rs     = {rem_q, dvd_q[23]};
	assign rs_ge  = rs >= {1'b0, dsr_q};
	assign pl_ext = 17'(plen_q) + 17'(plen_q >> 1);
	assign dl_ext = 10'(default_length_q) + 10'(default_length_q >> 1);
	assign idx    = prest_q ? 8'd0 : pti_q;
	assign tot_sat = (dvd_q > {8'd0, TICK_LIM}) ? TICK_LIM : dvd_q[15:0];
	assign snd_prod = 20'(tot_sat) * 20'(quantize_q);
	assign idx_hi = mns_pkg::div12(idx);
	assign idx_lo = 4'(idx - 8'(idx_hi) * 8'd12);
	assign shamt  = 5'(mns_pkg::TOP_SHIFT - idx_hi);

	always_ff @(posedge clk) begin
		if (cmd.ld_byte) byte_q <= text_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q         <= 4'd4;
			default_length_q <= DEF_LEN;
			tempo_q          <= 8'd120;
			quantize_q       <= 4'd7;
			last_tone_q      <= 8'd0;
			mode_q           <= mns_pkg::M_IDLE;
			wm_q             <= mns_pkg::M_IDLE;
			acc_q            <= 8'd0;
			pti_q            <= 8'd0;
			prest_q          <= 1'b0;
			plen_q           <= 16'd0;
			tie_q            <= 1'b0;
			len_to_default_q <= 1'b0;
			dvd_q            <= 24'd0;
			rem_q            <= 8'd0;
			dsr_q            <= 8'd0;
			busy_q           <= 1'b0;
			cnt_q            <= 5'd0;
			ov_q             <= 1'b0;
			kind_q           <= mns_pkg::EV_NOTE;
			tone_q           <= 31'd0;
			chg_q            <= 1'b0;
			snd_q            <= 16'd0;
			tot_q            <= 16'd0;
			tied_q           <= 1'b0;
			last_q           <= 1'b0;
		end else begin
			if (ov_q && out_ready && !ld_word) ov_q <= 1'b0;
			if (busy_q) begin
				rem_q <= rs_ge ? 8'(rs - {1'b0, dsr_q}) : rs[7:0];
				dvd_q <= {dvd_q[22:0], rs_ge};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) busy_q <= 1'b0;
			end
			unique case (cmd.op)
				mns_pkg::OP_FIRST: begin
					unique case (fa)
						F_ACCUM: acc_q <= (acc_next > 12'd255) ? 8'd255 : acc_next[7:0];
						F_ACCID: begin
							if (!prest_q)
								pti_q <= (byte_q == mns_pkg::CH_MINUS) ? pti_q - 8'd1 : pti_q + 8'd1;
							mode_q <= mns_pkg::M_NOTE_BASE;
						end
						F_FIRSTDIG: begin
							acc_q  <= 8'(dval);
							mode_q <= mns_pkg::M_NOTE_DIG;
						end
						F_TO_DOT: wm_q <= mns_pkg::M_NOTE_DOT;
						F_NDIG_DIV, F_L_DIV: begin
							wm_q  <= (fa == F_L_DIV) ? mns_pkg::M_L_DOT : mns_pkg::M_NOTE_DOT;
							len_to_default_q <= (fa == F_L_DIV);
							dvd_q  <= WHOLE;
							rem_q  <= 8'd0;
							dsr_q  <= acc_q;
							cnt_q  <= 5'(DIV_STEPS);
							busy_q <= 1'b1;
						end
						F_OQ: begin
							if (mode_q == mns_pkg::M_NUM_O)
								octave_q <= (acc_q > 8'd15) ? 4'd15 : acc_q[3:0];
							else
								quantize_q <= (acc_q > 8'd15) ? 4'd15 : acc_q[3:0];
							wm_q <= mns_pkg::M_IDLE;
						end
						F_T_SET: begin
							tempo_q <= acc_q;
							wm_q    <= mns_pkg::M_IDLE;
						end
						F_EXT: begin
							if (byte_q == mns_pkg::CH_SEMI) mode_q <= mns_pkg::M_IDLE;
						end
						F_PASS: wm_q <= mode_q;
						F_NDIG_ERR, F_T_ERR, F_L_ERR: ;
						default: ;
					endcase
				end
				mns_pkg::OP_LEN_WB: begin
					if (len_to_default_q) default_length_q <= dvd_q[8:0];
					else plen_q <= dvd_q[15:0];
				end
				mns_pkg::OP_SECOND: begin
					if (wm_q == mns_pkg::M_NOTE_DOT) begin
						if (byte_q == mns_pkg::CH_DOT) begin
							plen_q <= pl_ext[16] ? 16'hFFFF : pl_ext[15:0];
							mode_q <= mns_pkg::M_NOTE_DOT;
						end else begin
							tie_q  <= (byte_q == mns_pkg::CH_AMP);
							dvd_q  <= 24'(plen_q) * 24'd125;
							rem_q  <= 8'd0;
							dsr_q  <= tempo_q;
							cnt_q  <= 5'(DIV_STEPS);
							busy_q <= 1'b1;
						end
					end else if (wm_q == mns_pkg::M_L_DOT && byte_q == mns_pkg::CH_DOT) begin
						default_length_q <= (dl_ext > 10'd511) ? 9'd511 : dl_ext[8:0];
						mode_q <= mns_pkg::M_L_DOT;
					end
				end
				mns_pkg::OP_THIRD: begin
					if (is_letter || byte_q == mns_pkg::CH_R) begin
						prest_q <= (byte_q == mns_pkg::CH_R);
						pti_q   <= (byte_q == mns_pkg::CH_R) ? 8'd0
							: 8'(octave_q) * 8'd12 + 8'(mns_pkg::letter_ofs(3'(byte_q - mns_pkg::CH_A)))
							+ 8'd12;
						plen_q  <= 16'(default_length_q);
						acc_q   <= 8'd0;
						mode_q  <= mns_pkg::M_NOTE_ACC;
					end else if (byte_q == mns_pkg::CH_LT) begin
						octave_q <= octave_q - 4'd1;
						mode_q   <= mns_pkg::M_IDLE;
					end else if (byte_q == mns_pkg::CH_GT) begin
						octave_q <= octave_q + 4'd1;
						mode_q   <= mns_pkg::M_IDLE;
					end else if (byte_q == mns_pkg::CH_O) begin
						acc_q <= 8'd0; mode_q <= mns_pkg::M_NUM_O;
					end else if (byte_q == mns_pkg::CH_Q) begin
						acc_q <= 8'd0; mode_q <= mns_pkg::M_NUM_Q;
					end else if (byte_q == mns_pkg::CH_L) begin
						acc_q <= 8'd0; mode_q <= mns_pkg::M_NUM_L;
					end else if (byte_q == mns_pkg::CH_T) begin
						acc_q <= 8'd0; mode_q <= mns_pkg::M_NUM_T;
					end else if (byte_q == mns_pkg::CH_DOLR) begin
						mode_q <= mns_pkg::M_EXT;
					end else begin
						mode_q <= mns_pkg::M_IDLE;
					end
				end
				mns_pkg::OP_LD_NOTE: begin
					ov_q        <= 1'b1;
					mode_q      <= mns_pkg::M_IDLE;
					chg_q       <= (idx != last_tone_q);
					last_tone_q <= cut_short ? 8'd0 : idx;
					tot_q       <= tot_sat;
					tied_q      <= tie_q;
					last_q      <= tie_q || !idle_err;
					if (prest_q) begin
						kind_q <= mns_pkg::EV_REST;
						tone_q <= 31'd0;
						snd_q  <= 16'd0;
					end else begin
						kind_q <= mns_pkg::EV_NOTE;
						tone_q <= mns_pkg::tone_tab(idx_lo) >> shamt;
						snd_q  <= cut_short ? snd_prod[18:3] : tot_sat;
					end
				end
				mns_pkg::OP_LD_ERR: begin
					ov_q   <= 1'b1;
					mode_q <= mns_pkg::M_IDLE;
					kind_q <= mns_pkg::EV_ERROR;
					tone_q <= 31'd0;
					chg_q  <= 1'b0;
					snd_q  <= 16'd0;
					tot_q  <= 16'd0;
					tied_q <= 1'b0;
					last_q <= 1'b1;
				end
				mns_pkg::OP_NONE: ;
				default: ;
			endcase
		end
	end

	assign out_valid    = ov_q;
	assign event_kind   = kind_q;
	assign tone_value   = tone_q;
	assign tone_changed = chg_q;
	assign sound_ticks  = snd_q;
	assign total_ticks  = tot_q;
	assign tied         = tied_q;
	assign last_of_run  = last_q;

`ifndef SYNTH
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> kind_q != 2'd3) else $error("bad event kind");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && kind_q == mns_pkg::EV_ERROR |-> tone_q == 31'd0 && tot_q == 16'd0 && last_q)
		else $error("error word carries data");
	a_rest_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && kind_q == mns_pkg::EV_REST |-> snd_q == 16'd0 && tone_q == 31'd0)
		else $error("rest word sounds");
	a_snd_le_tot: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> snd_q <= tot_q) else $error("sound exceeds total");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mns_pkg::OP_LD_NOTE || cmd.op == mns_pkg::OP_LD_ERR) |-> slot_free)
		else $error("result overwritten");
`endif

endmodule
